// File: design/bitmap_first_fit_allocator_unit_defines.svh
// Assertion macros shared by the bitmap first-fit allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bffa_pkg.sv
// Package of the bitmap first-fit allocator: field widths, codes and word types.
// Depends on nothing; used by the top level, the sequencer and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package bffa_pkg;

    // Field widths of the input and result words.
    localparam int MODE_W   = 2;
    localparam int START_W  = 10;
    localparam int LEN_W    = 11;
    localparam int STATUS_W = 2;
    localparam int RUN_W    = 10;
    localparam int BIU_W    = 8;

    // Default bitmap size in bytes and reset value of the window register.
    localparam int              MAP_BYTES_DEF = 128;
    localparam logic [BIU_W-1:0] BIU_RESET    = 8'd128;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND    = 2'd2;

    // Register index of the window register.
    localparam logic REG_BYTES_IN_USE = 1'b0;

    // One request word.
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [START_W-1:0] start_req;
        logic [LEN_W-1:0]   length;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RUN_W-1:0]    run_start;
    } t_result;

endpackage

`default_nettype wire

// File: design/bitmap_first_fit_allocator_unit.sv
// Operation: search scans the window and marking reads and rewrites the bytes spanned,
// one bitmap byte per cycle; other and rejected requests go straight to the result word.
// Flow: one request at a time; the next word is taken once the result is passed on.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every bitmap byte in
// turn, during which no request word is taken. The window register resets to 128.
// Top level of the bitmap first-fit allocator; depends on bffa_pkg, bffa_ctrl, bffa_bitmap_ram.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_first_fit_allocator_unit
    import bffa_pkg::*;
#(
    parameter int MAP_BYTES = MAP_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // start_req [9:0], length [20:10], zero [23:21]
    input  wire logic [1:0]  s_axis_tuser,  // mode [1:0]
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,  // run_start [9:0], zero [15:10]
    output logic      [1:0]  m_axis_tuser,  // status [1:0]
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    logic [BIU_W-1:0] r_bytes_in_use;
    t_item            item;
    logic             res_valid;
    logic             res_ready;
    t_result          res;
    logic             r_out_vld;
    t_result          r_out;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AW-1:0]    raddr;
    logic [7:0]       rdata;

    // Window register write and read-back.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_use <= BIU_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BYTES_IN_USE) begin
            r_bytes_in_use <= pwdata[BIU_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_BYTES_IN_USE) ? {{(32 - BIU_W){1'b0}}, r_bytes_in_use}
                                                   : '0;

    // Request word unpacking.
    assign item.mode      = s_axis_tuser;
    assign item.start_req = s_axis_tdata[START_W-1:0];
    assign item.length    = s_axis_tdata[START_W+LEN_W-1:START_W];

    bffa_ctrl #(
        .MAP_BYTES (MAP_BYTES),
        .AW        (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_item         (item),
        .i_bytes_in_use (r_bytes_in_use),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_re           (re),
        .o_raddr        (raddr),
        .i_rdata        (rdata)
    );

    bffa_bitmap_ram #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Output register: a finished result waits here while the next request starts.
    assign res_ready = !r_out_vld || m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(16 - RUN_W){1'b0}}, r_out.run_start};
    assign m_axis_tuser  = r_out.status;

endmodule

`default_nettype wire

// File: design/bffa_bitmap_ram.sv
// Bitmap storage of the allocator: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module bffa_bitmap_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/bffa_ctrl.sv
// Sequencer of the allocator: clearing pass, first-fit byte scan and range marking
// by read-modify-write of the bitmap memory. Depends on bffa_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_first_fit_allocator_unit_defines.svh"

module bffa_ctrl
    import bffa_pkg::*;
#(
    parameter int MAP_BYTES = MAP_BYTES_DEF,
    parameter int AW        = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Request word
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_item            i_item,
    // Window register
    input  wire logic [BIU_W-1:0] i_bytes_in_use,
    // Result word
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output t_result               o_res,
    // Bitmap memory
    output logic                  o_we,
    output logic      [AW-1:0]    o_waddr,
    output logic      [7:0]       o_wdata,
    output logic                  o_re,
    output logic      [AW-1:0]    o_raddr,
    input  wire logic [7:0]       i_rdata
);

    // Unit index width, sum width and window compare width.
    localparam int UW  = AW + 3;
    localparam int SW  = (UW + 1 > 12) ? UW + 1 : 12;
    localparam int WW  = (AW + 1 > BIU_W) ? AW + 1 : BIU_W;
    localparam logic [SW-1:0] TOTAL_UNITS = SW'(8 * MAP_BYTES);
    localparam logic [AW-1:0] LAST_BYTE   = AW'(MAP_BYTES - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_MARK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_issue_addr, n_issue_addr;
    logic               r_issue_done, n_issue_done;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_addr;
    logic [AW-1:0]      r_last, n_last;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [START_W-1:0] r_start, n_start;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [SW-1:0]      r_end, n_end;
    logic [LEN_W-1:0]   r_count, n_count;
    logic [UW-1:0]      r_begin, n_begin;
    t_result            r_res, n_res;

    logic [SW-1:0]      sum_end;
    logic [WW-1:0]      win_bytes;
    logic [LEN_W-1:0]   scan_cnt;
    logic [UW-1:0]      scan_beg;
    logic               scan_hit;
    logic [7:0]         mark_mask;
    logic [SW-1:0]      unit_ix;

    // Per-byte scan: eight units, most significant bit first.
    always_comb begin
        scan_cnt = r_count;
        scan_beg = r_begin;
        scan_hit = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!scan_hit) begin
                if (!i_rdata[3'(7 - i)]) begin
                    if (scan_cnt == '0) begin
                        scan_beg = {r_rd_addr, 3'(i)};
                    end
                    scan_cnt = scan_cnt + 1'b1;
                    if (scan_cnt == r_len) begin
                        scan_hit = 1'b1;
                    end
                end else begin
                    scan_cnt = '0;
                end
            end
        end
    end

    // Bits of the byte in flight that fall inside the marked range.
    always_comb begin
        mark_mask = '0;
        unit_ix   = '0;
        for (int i = 0; i < 8; i++) begin
            unit_ix = SW'({r_rd_addr, 3'(i)});
            mark_mask[3'(7 - i)] = (unit_ix >= SW'(r_start)) && (unit_ix < r_end);
        end
    end

    assign sum_end   = SW'(i_item.start_req) + SW'(i_item.length);
    assign win_bytes = (WW'(i_bytes_in_use) > WW'(MAP_BYTES)) ? WW'(MAP_BYTES)
                                                             : WW'(i_bytes_in_use);

    // Next-state logic and memory port control.
    always_comb begin
        n_state      = r_state;
        n_issue_addr = r_issue_addr;
        n_issue_done = r_issue_done;
        n_last       = r_last;
        n_mode       = r_mode;
        n_start      = r_start;
        n_len        = r_len;
        n_end        = r_end;
        n_count      = r_count;
        n_begin      = r_begin;
        n_res        = r_res;
        o_ready      = 1'b0;
        o_res_valid  = 1'b0;
        o_re         = 1'b0;
        o_raddr      = r_issue_addr;
        o_we         = 1'b0;
        o_waddr      = r_rd_addr;
        o_wdata      = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_we         = 1'b1;
                o_waddr      = r_issue_addr;
                n_issue_addr = r_issue_addr + 1'b1;
                if (r_issue_addr == LAST_BYTE) begin
                    n_issue_addr = '0;
                    n_state      = S_IDLE;
                end
            end

            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_mode           = i_item.mode;
                    n_start          = i_item.start_req;
                    n_len            = i_item.length;
                    n_end            = sum_end;
                    n_count          = '0;
                    n_begin          = '0;
                    n_issue_done     = 1'b0;
                    n_res.status     = ST_OK;
                    n_res.run_start  = '0;
                    n_state          = S_DONE;
                    if (i_item.mode == MODE_SEARCH) begin
                        if (i_item.length == '0 || win_bytes == '0) begin
                            n_res.status = ST_NOT_FOUND;
                        end else begin
                            n_issue_addr = '0;
                            n_last       = AW'(win_bytes - 1'b1);
                            n_state      = S_SCAN;
                        end
                    end else if (i_item.mode == MODE_ALLOC || i_item.mode == MODE_FREE) begin
                        if (sum_end > TOTAL_UNITS) begin
                            n_res.status = ST_BEYOND;
                        end else if (i_item.length != '0) begin
                            n_issue_addr = AW'(SW'(i_item.start_req) >> 3);
                            n_last       = AW'((sum_end - 1'b1) >> 3);
                            n_state      = S_MARK;
                        end
                    end
                end
            end

            S_SCAN: begin
                // Issue the next byte read while the previous one is examined.
                if (!r_issue_done) begin
                    o_re = 1'b1;
                    if (r_issue_addr == r_last) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_issue_addr = r_issue_addr + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    n_count = scan_cnt;
                    n_begin = scan_beg;
                    if (scan_hit) begin
                        n_res.status    = ST_OK;
                        n_res.run_start = RUN_W'(scan_beg);
                        n_state         = S_DONE;
                    end else if (r_rd_addr == r_last) begin
                        n_res.status = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end
                end
            end

            S_MARK: begin
                if (!r_issue_done) begin
                    o_re = 1'b1;
                    if (r_issue_addr == r_last) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_issue_addr = r_issue_addr + 1'b1;
                    end
                end
                // Write back the byte whose read was issued in the cycle before.
                if (r_rd_vld) begin
                    o_we    = 1'b1;
                    o_wdata = (r_mode == MODE_ALLOC) ? (i_rdata | mark_mask)
                                                     : (i_rdata & ~mark_mask);
                    if (r_rd_addr == r_last) begin
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_issue_addr <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue_addr <= n_issue_addr;
            r_issue_done <= n_issue_done;
            r_rd_vld     <= o_re;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_addr <= o_raddr;
        r_last    <= n_last;
        r_mode    <= n_mode;
        r_start   <= n_start;
        r_len     <= n_len;
        r_end     <= n_end;
        r_count   <= n_count;
        r_begin   <= n_begin;
        r_res     <= n_res;
    end

    assign o_res = r_res;

    // Checks on the sequencer.
    `BFFA_ASSERT_NOW(a_write_only_clear_mark, i_clk, i_rst_n, o_we,
        (r_state == S_CLEAR || r_state == S_MARK), "bitmap written outside clear or mark")
    `BFFA_ASSERT_NOW(a_mark_writes_read_byte, i_clk, i_rst_n, (r_state == S_MARK && o_we),
        (o_waddr == $past(o_raddr)), "mark writes a byte other than the one read")
    `BFFA_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, (r_state == S_DONE && !i_res_ready),
        (r_state == S_DONE && $stable(r_res)), "pending result changed before delivery")
    `BFFA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, (i_valid && o_ready),
        (r_state != S_IDLE), "accepted request did not start work")

endmodule

`default_nettype wire

// File: sim/bitmap_first_fit_allocator_unit_checker.sv
// Scoreboard for the bitmap first-fit allocator: watches request, result and register traffic,
// keeps its own copy of the bitmap and window register, and compares every result word.
// Depends on bffa_pkg for field widths, modes and status codes.
`timescale 1ns / 1ps

module bitmap_first_fit_allocator_unit_checker
    import bffa_pkg::*;
#(
    parameter int MAP_BYTES = MAP_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream as seen on the block's slave side
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [23:0] i_req_data,  // start_req [9:0], length [20:10], zero [23:21]
    input  logic [1:0]  i_req_user,  // mode [1:0]
    // Result stream as seen on the block's master side
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [15:0] i_res_data,  // run_start [9:0], zero [15:10]
    input  logic [1:0]  i_res_user,  // status [1:0]
    // Register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_results
);

    localparam logic [2:0] ADDR_BYTES_IN_USE = {REG_BYTES_IN_USE, 2'b00};

    // Shadow bitmap, one bit per unit, unit u at bit 7 - (u mod 8) of byte u / 8.
    logic [7:0]  unit_map [MAP_BYTES];
    logic [7:0]  window_bytes;
    t_result     outcomes_due [$];
    int          mismatch_count = 0;
    int          result_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_results    = result_count;

    initial o_pending = 0;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    // Applies one request to the shadow bitmap and returns the result word it should produce.
    function automatic t_result allocator_outcome(input t_item req);
        t_result res;
        int      span;
        int      units;
        int      run_len;
        int      first;
        int      u;
        int      last;
        bit      found;
        res.status    = ST_OK;
        res.run_start = '0;
        case (req.mode)
            MODE_SEARCH: begin
                // First-fit scan over the window, saturated to the map size.
                span    = (window_bytes > MAP_BYTES) ? MAP_BYTES : int'(window_bytes);
                units   = span * 8;
                run_len = 0;
                first   = 0;
                found   = 1'b0;
                if (req.length != '0) begin
                    for (u = 0; u < units && !found; u++) begin
                        if (unit_map[u / 8][7 - u % 8] == 1'b0) begin
                            if (run_len == 0) first = u;
                            run_len++;
                            if (run_len == int'(req.length)) found = 1'b1;
                        end else begin
                            run_len = 0;
                        end
                    end
                end
                if (found) res.run_start = first[RUN_W-1:0];
                else res.status = ST_NOT_FOUND;
            end
            MODE_ALLOC, MODE_FREE: begin
                // A range running past the end of the map leaves the map untouched.
                last = int'(req.start_req) + int'(req.length);
                if (last > MAP_BYTES * 8) begin
                    res.status = ST_BEYOND;
                end else begin
                    for (u = int'(req.start_req); u < last; u++)
                        unit_map[u / 8][7 - u % 8] = (req.mode == MODE_ALLOC);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Tracks register writes, predicts on accepted requests and checks accepted results.
    always @(posedge i_clk) begin
        t_item   req;
        t_result want;
        if (!i_rst_n) begin
            foreach (unit_map[b]) unit_map[b] = 8'h00;
            window_bytes = BIU_RESET;
            outcomes_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_BYTES_IN_USE)
                window_bytes = i_pwdata[BIU_W-1:0];
            if (i_req_valid && i_req_ready) begin
                req.mode      = i_req_user;
                req.start_req = i_req_data[START_W-1:0];
                req.length    = i_req_data[START_W+LEN_W-1:START_W];
                outcomes_due.push_back(allocator_outcome(req));
            end
            if (i_res_valid && i_res_ready) begin
                result_count++;
                if (outcomes_due.size() == 0) begin
                    report_mismatch("unexpected result word, status", -1, int'(i_res_user));
                end else begin
                    want = outcomes_due.pop_front();
                    if (i_res_user !== want.status)
                        report_mismatch("status", int'(want.status), int'(i_res_user));
                    if (i_res_data[RUN_W-1:0] !== want.run_start)
                        report_mismatch("run_start", int'(want.run_start),
                                        int'(i_res_data[RUN_W-1:0]));
                end
            end
        end
        o_pending <= outcomes_due.size();
    end

endmodule

// File: sim/bitmap_first_fit_allocator_unit_tb.sv
// Top of the allocator testbench: clock, reset, request and register stimulus, result stalls.
// Depends on bffa_pkg, bitmap_first_fit_allocator_unit and bitmap_first_fit_allocator_unit_checker.
`timescale 1ns / 1ps

module bitmap_first_fit_allocator_unit_tb;
    import bffa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED       = 2'd3;
    localparam logic [2:0]        ADDR_BYTES_IN_USE = {REG_BYTES_IN_USE, 2'b00};
    localparam int                ITEMS_PER_PHASE   = 86;
    localparam int                HOLD_CYCLES       = 400;
    localparam int                TAIL_CYCLES       = 140;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;  // start_req [9:0], length [20:10], zero [23:21]
    logic [1:0]  s_axis_tuser  = '0;  // mode [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // run_start [9:0], zero [15:10]
    logic [1:0]  m_axis_tuser;        // status [1:0]
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int results_checked;
    int idle_pct      = 9;
    bit hold_off_req  = 1'b0;
    int words_sent    = 0;

    always #10 i_clk = ~i_clk;

    bitmap_first_fit_allocator_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    bitmap_first_fit_allocator_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results_checked)
    );

    // Offers one request word, with random idle cycles ahead of it, until it is taken.
    task automatic send_request(input logic [MODE_W-1:0] mode, input int start_unit,
                                input int run_len);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, run_len[LEN_W-1:0], start_unit[START_W-1:0]};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // Stops offering and waits until every expected result word has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Writes the window register through a setup and an access cycle.
    task automatic write_window(input logic [BIU_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BYTES_IN_USE;
        pwdata  <= {24'h0, value};
        @(posedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random request: mostly short runs and marks, some long or out-of-range lengths.
    task automatic send_random_request();
        logic [MODE_W-1:0] mode;
        int                start_unit;
        int                run_len;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 40) mode = MODE_SEARCH;
        else if (pick < 70) mode = MODE_ALLOC;
        else if (pick < 95) mode = MODE_FREE;
        else mode = MODE_UNUSED;
        // Keep a share of the marks in the low bytes so small windows see changes.
        start_unit = ($urandom_range(99) < 30) ? $urandom_range(63) : $urandom_range(1023);
        pick = $urandom_range(99);
        if (pick < 60) run_len = $urandom_range(1, 24);
        else if (pick < 82) run_len = $urandom_range(1, 1024);
        else if (pick < 90) run_len = 0;
        else run_len = $urandom_range(1025, 2047);
        send_request(mode, start_unit, run_len);
    endtask

    // Result side: random stalls, and one long hold-off when the stimulus asks for it.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Main stimulus: directed corner cases, then random phases over several windows.
    initial begin
        logic [BIU_W-1:0] window_plan [7];
        window_plan = '{8'd1, 8'd0, 8'd255, 8'd128, 8'd40, 8'd0, 8'd128};
        window_plan[5] = BIU_W'($urandom_range(2, 127));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the window at its reset value and an empty map.
        send_request(MODE_SEARCH, 0, 0);
        send_request(MODE_SEARCH, 1023, 1);
        send_request(MODE_SEARCH, 0, 1024);
        send_request(MODE_SEARCH, 0, 1025);
        send_request(MODE_ALLOC, 0, 0);
        send_request(MODE_ALLOC, 1023, 0);
        send_request(MODE_ALLOC, 1023, 1);
        send_request(MODE_ALLOC, 1023, 2);
        send_request(MODE_ALLOC, 0, 2047);
        send_request(MODE_ALLOC, 0, 3);
        send_request(MODE_SEARCH, 0, 1);
        send_request(MODE_SEARCH, 0, 1020);
        send_request(MODE_SEARCH, 0, 1021);
        send_request(MODE_ALLOC, 5, 10);
        send_request(MODE_SEARCH, 0, 2);
        send_request(MODE_SEARCH, 0, 3);
        send_request(MODE_FREE, 6, 4);
        send_request(MODE_SEARCH, 0, 4);
        send_request(MODE_UNUSED, 1023, 2047);
        send_request(MODE_FREE, 0, 1024);
        send_request(MODE_ALLOC, 0, 1024);
        send_request(MODE_SEARCH, 0, 1);
        send_request(MODE_FREE, 512, 512);
        send_request(MODE_SEARCH, 0, 512);
        send_request(MODE_FREE, 0, 1024);
        drain_results();

        // Random phases; the window only changes while nothing is in flight.
        for (int p = 0; p < 7; p++) begin
            write_window(window_plan[p]);
            idle_pct = (p == 4) ? 0 : 9;
            if (p == 2) hold_off_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) send_random_request();
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d request words over the directed set and %0d window settings,",
                 words_sent, 7);
        $display("including zero, one, full and saturated windows; %0d result words checked.",
                 results_checked);
        if (mismatches == 0) begin
            $display("bitmap_first_fit_allocator_unit_tb: PASS");
        end else begin
            $display("bitmap_first_fit_allocator_unit_tb: FAIL");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("Timeout with %0d result words still expected.", pending);
        $display("bitmap_first_fit_allocator_unit_tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/bffa_pkg.sv
design/bffa_bitmap_ram.sv
design/bffa_ctrl.sv
design/bitmap_first_fit_allocator_unit.sv
sim/bitmap_first_fit_allocator_unit_checker.sv
sim/bitmap_first_fit_allocator_unit_tb.sv
